// ===== rtl/sks_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and codes for the sorted key set table.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int KEY_W        = 32;
    localparam int ENTRIES_W    = 5;
    localparam int DEF_CAPACITY = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] key;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] value;
        logic [ENTRIES_W-1:0]    entries;
    } t_res_word;

endpackage

// ===== rtl/sorted_key_set_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_set_table
// Set of distinct signed keys held in ascending order in a single-port-read
// memory; insert, delete and search run on one compare unit under a sequencer.
// ----------------------------------------------------------------------------
//  channel   | handshake            | word
//  ----------+----------------------+-------------------------------------
//  command   | start, busy          | i_cmd  : command, key
//  result    | o_strobe (1 cycle)   | o_res  : status, value, entries
//
//  A command scans the entries in ascending order up to its key, then an
//  insert or delete moves the entries behind that position one place, and
//  an insert that stores writes the key last. Both the scan and the move run
//  through the one memory read port with its registered read data.
//  Reset is synchronous and clears the count; the memory needs no clearing.
//  busy drops in the cycle the result strobe is shown; results cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_set_table #(
    parameter int CAPACITY = sks_pkg::DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sks_pkg::t_cmd_word i_cmd,
    output logic              o_strobe,
    output sks_pkg::t_res_word o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_PUT
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic r_hit, n_hit;
    logic [1:0] r_op, n_op;
    logic signed [sks_pkg::KEY_W-1:0] r_key, n_key;
    logic r_strobe, n_strobe;
    sks_pkg::t_res_word r_res, n_res;

    logic signed [sks_pkg::KEY_W-1:0] mem [CAPACITY];
    logic signed [sks_pkg::KEY_W-1:0] r_rd;
    logic mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic signed [sks_pkg::KEY_W-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_hit    = r_hit;
        n_op     = r_op;
        n_key    = r_key;
        n_strobe = 1'b0;
        n_res    = r_res;
        mem_we   = 1'b0;
        mem_wa   = r_idx[AW-1:0];
        mem_wd   = r_rd;
        mem_ra   = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_cmd.command;
                    n_key = i_cmd.key;
                    n_idx = '0;
                    n_pos = '0;
                    n_hit = 1'b0;
                    n_state = (r_count == '0) ? S_EXEC : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                // r_rd holds entry r_idx
                if (r_rd < r_key) begin
                    if (CW'(r_idx + 1'b1) == r_count) begin
                        n_pos   = r_count;
                        n_hit   = 1'b0;
                        n_state = S_EXEC;
                    end else begin
                        n_idx   = CW'(r_idx + 1'b1);
                        n_state = S_RD;
                    end
                end else begin
                    n_pos   = r_idx;
                    n_hit   = (r_rd == r_key);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.value   = r_key;
                n_res.entries = sks_pkg::ENTRIES_W'(r_count);
                case (r_op)
                    sks_pkg::CMD_INSERT: begin
                        if (r_hit) begin
                            n_res.status = sks_pkg::ST_DUP;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end else if (r_count == CW'(CAPACITY)) begin
                            n_res.status = sks_pkg::ST_FULL;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            n_idx   = r_count;
                            n_state = (r_count == r_pos) ? S_PUT : S_SH_RD;
                        end
                    end
                    sks_pkg::CMD_DELETE: begin
                        if (r_hit) begin
                            if (CW'(r_pos + 1'b1) == r_count) begin
                                n_count       = CW'(r_count - 1'b1);
                                n_res.status  = sks_pkg::ST_DONE;
                                n_res.entries = sks_pkg::ENTRIES_W'(CW'(r_count - 1'b1));
                                n_strobe      = 1'b1;
                                n_state       = S_IDLE;
                            end else begin
                                n_idx   = r_pos;
                                n_state = S_SH_RD;
                            end
                        end else begin
                            n_res.status = sks_pkg::ST_MISS;
                            n_strobe     = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        // search, and the unused code that decodes as search
                        n_res.status = r_hit ? sks_pkg::ST_DONE : sks_pkg::ST_MISS;
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_SH_RD: begin
                if (r_op == sks_pkg::CMD_INSERT) begin
                    mem_ra = AW'(CW'(r_idx - 1'b1));
                end else begin
                    mem_ra = AW'(CW'(r_idx + 1'b1));
                end
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                if (r_op == sks_pkg::CMD_INSERT) begin
                    n_idx   = CW'(r_idx - 1'b1);
                    n_state = (CW'(r_idx - 1'b1) == r_pos) ? S_PUT : S_SH_RD;
                end else begin
                    n_idx = CW'(r_idx + 1'b1);
                    if (CW'(r_idx + 2'd2) == r_count) begin
                        n_count       = CW'(r_count - 1'b1);
                        n_res.status  = sks_pkg::ST_DONE;
                        n_res.entries = sks_pkg::ENTRIES_W'(CW'(r_count - 1'b1));
                        n_strobe      = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_state = S_SH_RD;
                    end
                end
            end
            S_PUT: begin
                mem_we        = 1'b1;
                mem_wa        = r_pos[AW-1:0];
                mem_wd        = r_key;
                n_count       = CW'(r_count + 1'b1);
                n_res.status  = sks_pkg::ST_DONE;
                n_res.entries = sks_pkg::ENTRIES_W'(CW'(r_count + 1'b1));
                n_strobe      = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_hit <= n_hit;
        r_op  <= n_op;
        r_key <= n_key;
        r_res <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== rtl/sks_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sks_chk
// Port-level checks on the command/result sequencing of the key set table.
// ----------------------------------------------------------------------------
module sks_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_strobe,
    input sks_pkg::t_res_word o_res
);

    // an accepted word raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // the result is shown only once the block is free again
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // every finished command ends with exactly its result
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_strobe)
        else $error("command finished without a result");

    a_dup_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.status == sks_pkg::ST_FULL) |-> o_res.entries != '0)
        else $error("full reported with no entries");

endmodule

bind sorted_key_set_table sks_chk u_sks_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
